/* sv/spq_pkg.sv */
package spq_pkg;

    localparam int DEPTH     = 16;
    localparam int TAG_BITS  = 16;
    localparam int LVL_W     = 3;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam logic [LVL_W-1:0] MAX_LEVEL = LVL_W'(5);

    // Operation carried by each input word.
    typedef enum logic [1:0] {
        KIND_ENQ = 2'd0,
        KIND_DEQ = 2'd1,
        KIND_CLR = 2'd2,
        KIND_NOP = 2'd3
    } t_kind;

    // Result status.
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // What every cell of the chain does on a clock edge.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_POP    = 2'd2
    } t_cell_op;

    typedef struct packed {
        logic [LVL_W-1:0]    level;
        logic [TAG_BITS-1:0] tag;
    } t_entry;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        t_cell_op op;
        t_entry   new_entry;
    } t_cell_ctl;

endpackage

/* sv/spq_cell.sv */
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic               i_valid,
    input  logic               i_prev_goes,
    input  spq_pkg::t_entry    i_left,
    input  spq_pkg::t_entry    i_right,
    output spq_pkg::t_entry    o_entry,
    output logic               o_goes
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // The new entry belongs at or before this cell when this cell is empty
    // or holds a strictly lower level.
    assign o_goes  = !(i_valid && (r_entry.level >= i_ctl.new_entry.level));
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            spq_pkg::CELL_INSERT: begin
                if (o_goes && !i_prev_goes) begin
                    n_entry = i_ctl.new_entry;
                end else if (o_goes) begin
                    n_entry = i_left;
                end
            end
            spq_pkg::CELL_POP: begin
                n_entry = i_right;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

/* sv/stable_priority_queue.sv */
// Stable priority queue built as a sorted chain of entry cells.
// The result word for an operation is captured in a one-entry output
// register when the input word is accepted. Throughput: one operation per
// cycle while the receiver drains that register, else the input is stalled.
// Reset (synchronous, active low) empties the queue and drops any pending
// result word; cell contents are not cleared and are never read while empty.
module stable_priority_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,  // level[2:0], tag[18:3], zero fill
    input  logic [1:0]  i_s_tuser,  // kind[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata   // status[1:0], out_tag[17:2],
                                    // out_level[20:18], occupancy[25:21], zero fill
);

    // Occupancy counter; the cells below it hold valid entries, kept in
    // service order (highest level first, arrival order within a level).
    logic [spq_pkg::CNT_W-1:0] r_count;
    logic [spq_pkg::CNT_W-1:0] n_count;

    // Output register holding one result word.
    logic                         r_m_valid;
    spq_pkg::t_status             r_status;
    logic [spq_pkg::TAG_BITS-1:0] r_out_tag;
    logic [spq_pkg::LVL_W-1:0]    r_out_level;
    logic [spq_pkg::CNT_W-1:0]    r_occ;

    spq_pkg::t_status             n_status;
    logic [spq_pkg::TAG_BITS-1:0] n_out_tag;
    logic [spq_pkg::LVL_W-1:0]    n_out_level;

    logic                      accept;
    spq_pkg::t_kind            kind;
    logic [spq_pkg::LVL_W-1:0] in_level;
    logic [spq_pkg::LVL_W-1:0] sat_level;
    spq_pkg::t_cell_ctl        ctl;
    logic                      full;
    logic                      empty;

    spq_pkg::t_entry cell_entry [spq_pkg::DEPTH];
    logic            cell_goes  [spq_pkg::DEPTH];
    logic            cell_valid [spq_pkg::DEPTH];

    // A new word is taken whenever the output register is free or is being
    // drained in this same cycle.
    assign o_s_tready = !r_m_valid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    assign kind      = spq_pkg::t_kind'(i_s_tuser);
    assign in_level  = i_s_tdata[spq_pkg::LVL_W-1:0];
    // Levels above the top level are stored as the top level.
    assign sat_level = (in_level > spq_pkg::MAX_LEVEL) ? spq_pkg::MAX_LEVEL : in_level;

    assign full  = (r_count == spq_pkg::CNT_W'(spq_pkg::DEPTH));
    assign empty = (r_count == '0);

    always_comb begin
        ctl.new_entry.level = sat_level;
        ctl.new_entry.tag   = i_s_tdata[spq_pkg::LVL_W +: spq_pkg::TAG_BITS];
        ctl.op              = spq_pkg::CELL_HOLD;
        n_count             = r_count;
        n_status            = spq_pkg::ST_DONE;
        n_out_tag           = '0;
        n_out_level         = '0;
        if (accept) begin
            case (kind)
                spq_pkg::KIND_ENQ: begin
                    if (full) begin
                        n_status = spq_pkg::ST_FULL;
                    end else begin
                        ctl.op  = spq_pkg::CELL_INSERT;
                        n_count = r_count + 1'b1;
                    end
                end
                spq_pkg::KIND_DEQ: begin
                    if (empty) begin
                        n_status = spq_pkg::ST_EMPTY;
                    end else begin
                        ctl.op      = spq_pkg::CELL_POP;
                        n_count     = r_count - 1'b1;
                        n_out_tag   = cell_entry[0].tag;
                        n_out_level = cell_entry[0].level;
                    end
                end
                spq_pkg::KIND_CLR: begin
                    n_count = '0;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    // The chain: each cell sees its left neighbor for an insert shift and
    // its right neighbor for a pop shift.
    for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
        spq_pkg::t_entry left_entry;
        spq_pkg::t_entry right_entry;
        logic            prev_goes;

        assign cell_valid[i] = (spq_pkg::CNT_W'(i) < r_count);

        if (i == 0) begin : g_first
            assign left_entry = ctl.new_entry;
            assign prev_goes  = 1'b0;
        end else begin : g_inner
            assign left_entry = cell_entry[i-1];
            assign prev_goes  = cell_goes[i-1];
        end

        if (i == spq_pkg::DEPTH - 1) begin : g_last
            assign right_entry = cell_entry[i];
        end else begin : g_body
            assign right_entry = cell_entry[i+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_valid     (cell_valid[i]),
            .i_prev_goes (prev_goes),
            .i_left      (left_entry),
            .i_right     (right_entry),
            .o_entry     (cell_entry[i]),
            .o_goes      (cell_goes[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= n_status;
            r_out_tag   <= n_out_tag;
            r_out_level <= n_out_level;
            r_occ       <= n_count;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {6'd0, r_occ, r_out_level, r_out_tag, r_status};

    // The occupancy never exceeds the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= spq_pkg::CNT_W'(spq_pkg::DEPTH))
        else $error("occupancy above depth");

    // The two front entries are always in service order.
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= spq_pkg::CNT_W'(2)) |-> (cell_entry[1].level <= cell_entry[0].level))
        else $error("head entries out of order");

    // An accepted enqueue into a store with room grows it by one.
    a_enq_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (kind == spq_pkg::KIND_ENQ) && !full)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("enqueue did not grow the store");

    // A successful dequeue reports the level that was at the head.
    a_deq_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (kind == spq_pkg::KIND_DEQ) && !empty)
        |=> (r_out_level == $past(cell_entry[0].level)))
        else $error("dequeue level differs from head");

    // A clear empties the store.
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (kind == spq_pkg::KIND_CLR)) |=> (r_count == '0))
        else $error("clear left entries behind");

endmodule

/* tb/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Input word on i_s_tdata, first field in the lowest bits.
    typedef struct packed {
        logic [4:0]                   fill;
        logic [spq_pkg::TAG_BITS-1:0] tag;
        logic [spq_pkg::LVL_W-1:0]    level;
    } t_op_word;

    // Result word on o_m_tdata, first field in the lowest bits.
    typedef struct packed {
        logic [5:0]                   fill;
        logic [spq_pkg::CNT_W-1:0]    occupancy;
        logic [spq_pkg::LVL_W-1:0]    out_level;
        logic [spq_pkg::TAG_BITS-1:0] out_tag;
        spq_pkg::t_status             status;
    } t_result;

    // How the receiver drives its ready between long stalls.
    typedef enum logic [1:0] {
        RX_ALWAYS  = 2'd0,
        RX_RANDOM  = 2'd1,
        RX_PATTERN = 2'd2
    } t_rx_mode;

    // Keeps a copy of the queue contents in service order, works out the
    // result word of every accepted operation and compares the block's
    // result words against those, oldest first.
    class queue_scoreboard;
        spq_pkg::t_entry entries[$];
        t_result         expected_words[$];
        int unsigned     failures;
        int unsigned     n_checked;
        int unsigned     n_stored, n_served, n_refused, n_empty_deq, n_cleared, n_ignored;
        int unsigned     peak_depth;

        function void apply_operation(spq_pkg::t_kind kind,
                                      logic [spq_pkg::LVL_W-1:0] level,
                                      logic [spq_pkg::TAG_BITS-1:0] tag);
            t_result         want;
            spq_pkg::t_entry e;
            int              pos;
            want = '0;
            want.status = spq_pkg::ST_DONE;
            case (kind)
                spq_pkg::KIND_ENQ: begin
                    if (entries.size() >= spq_pkg::DEPTH) begin
                        want.status = spq_pkg::ST_FULL;
                        n_refused++;
                    end else begin
                        e.level = (level > spq_pkg::MAX_LEVEL) ? spq_pkg::MAX_LEVEL : level;
                        e.tag   = tag;
                        // Behind every entry of equal or higher level.
                        pos = 0;
                        while (pos < entries.size() && entries[pos].level >= e.level)
                            pos++;
                        entries.insert(pos, e);
                        n_stored++;
                    end
                end
                spq_pkg::KIND_DEQ: begin
                    if (entries.size() == 0) begin
                        want.status = spq_pkg::ST_EMPTY;
                        n_empty_deq++;
                    end else begin
                        e = entries.pop_front();
                        want.out_tag   = e.tag;
                        want.out_level = e.level;
                        n_served++;
                    end
                end
                spq_pkg::KIND_CLR: begin
                    entries.delete();
                    n_cleared++;
                end
                default: n_ignored++;
            endcase
            want.occupancy = spq_pkg::CNT_W'(entries.size());
            if (entries.size() > peak_depth)
                peak_depth = entries.size();
            expected_words.push_back(want);
        endfunction

        function void check_result(logic [31:0] word);
            t_result got;
            t_result want;
            got = t_result'(word);
            if (expected_words.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result word %h with nothing outstanding", word);
                return;
            end
            want = expected_words.pop_front();
            n_checked++;
            if (got.status !== want.status || got.out_tag !== want.out_tag ||
                    got.out_level !== want.out_level || got.occupancy !== want.occupancy) begin
                failures++;
                if (failures <= 10)
                    $display({"result %0d: expected status %0d tag %h level %0d depth %0d, ",
                              "got status %0d tag %h level %0d depth %0d"},
                             n_checked, want.status, want.out_tag, want.out_level,
                             want.occupancy, got.status, got.out_tag, got.out_level,
                             got.occupancy);
            end
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           s_valid;
    logic           s_ready;
    t_op_word       s_word;
    spq_pkg::t_kind s_kind;
    logic           m_valid;
    logic           m_ready;
    logic [31:0]    m_data;

    queue_scoreboard sb;

    // The stimulus side bumps this to ask the receiver for one long stall.
    int long_stalls_asked;

    stable_priority_queue u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_word),   // level[2:0], tag[18:3], zero fill
        .i_s_tuser  (s_kind),   // kind[1:0]
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data)    // status[1:0], out_tag[17:2], out_level[20:18],
                                // occupancy[25:21], zero fill
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offers one word from the falling edge on and holds it until the block
    // takes it. Back-to-back calls keep valid high across the words.
    task automatic send_op(input spq_pkg::t_kind kind,
                           input logic [spq_pkg::LVL_W-1:0] level,
                           input logic [spq_pkg::TAG_BITS-1:0] tag);
        @(negedge clk);
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_word  <= '{fill: '0, tag: tag, level: level};
        do @(posedge clk); while (!s_ready);
        sb.apply_operation(kind, level, tag);
    endtask

    // Sender gap. The data lines carry noise while valid is low.
    task automatic idle_cycles(input int n);
        repeat (n) begin
            @(negedge clk);
            s_valid <= 1'b0;
            s_word  <= '{fill: '0, tag: spq_pkg::TAG_BITS'($urandom),
                         level: spq_pkg::LVL_W'($urandom)};
        end
    endtask

    // Holds the sender off until every outstanding result word is back.
    task automatic wait_for_results();
        idle_cycles(1);
        while (sb.expected_words.size() != 0)
            @(posedge clk);
    endtask

    // Mostly legal levels, with the out-of-range codes now and then so that
    // saturation to the top level is exercised.
    function automatic logic [spq_pkg::LVL_W-1:0] pick_level();
        if ($urandom_range(0, 9) < 9)
            return spq_pkg::LVL_W'($urandom_range(0, 5));
        return spq_pkg::LVL_W'($urandom_range(6, 7));
    endfunction

    function automatic logic [spq_pkg::TAG_BITS-1:0] pick_tag();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            default: return spq_pkg::TAG_BITS'($urandom);
        endcase
    endfunction

    // Random traffic in bursts. The enqueue share drifts between filling,
    // draining and balanced so that the queue keeps swinging between empty
    // and full; clears and unused kinds are sprinkled in at a low rate.
    task automatic run_random_traffic(input int count);
        int             done_items;
        int             burst;
        int             enq_pct;
        int             roll;
        spq_pkg::t_kind kind;
        done_items = 0;
        enq_pct    = 50;
        while (done_items < count) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 2))
                    0:       enq_pct = 80;
                    1:       enq_pct = 25;
                    default: enq_pct = 50;
                endcase
            end
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && done_items < count; b++) begin
                roll = $urandom_range(0, 99);
                if (roll < 2)
                    kind = spq_pkg::KIND_CLR;
                else if (roll < 4)
                    kind = spq_pkg::KIND_NOP;
                else if ($urandom_range(0, 99) < enq_pct)
                    kind = spq_pkg::KIND_ENQ;
                else
                    kind = spq_pkg::KIND_DEQ;
                send_op(kind, pick_level(), pick_tag());
                done_items++;
                // The receiver stops for a long stretch while words keep coming,
                // so the output register fills and the input is backpressured.
                if (done_items == 400 || done_items == 1000)
                    long_stalls_asked++;
                if (done_items == 700 || done_items == 1300)
                    wait_for_results();
            end
            roll = $urandom_range(0, 9);
            if (roll < 3)
                idle_cycles(0);
            else if (roll < 9)
                idle_cycles($urandom_range(1, 4));
            else
                idle_cycles($urandom_range(5, 15));
        end
    endtask

    // Receiver: switches between always ready, coin-flip ready and a random
    // eight-bit pattern, and serves long stall requests by counting cycles.
    initial begin : receiver
        int         stalls_served;
        int         stall_left;
        int         mode_left;
        t_rx_mode   mode;
        logic [7:0] ready_pattern;
        stalls_served = 0;
        stall_left    = 0;
        mode_left     = 0;
        mode          = RX_ALWAYS;
        ready_pattern = 8'hFF;
        m_ready       = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_left == 0 && long_stalls_asked > stalls_served) begin
                stalls_served++;
                stall_left = 200;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                if (mode_left == 0) begin
                    mode          = t_rx_mode'(2'($urandom_range(0, 2)));
                    mode_left     = $urandom_range(20, 200);
                    ready_pattern = 8'($urandom);
                end
                mode_left--;
                case (mode)
                    RX_ALWAYS:  m_ready <= 1'b1;
                    RX_RANDOM:  m_ready <= 1'($urandom_range(0, 1));
                    default:    m_ready <= ready_pattern[3'(mode_left)];
                endcase
            end
        end
    end

    // Every accepted result word is checked against the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready)
            sb.check_result(m_data);
    end

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin : stimulus
        int guard;
        int leftover;
        sb                = new();
        long_stalls_asked = 0;
        rst_n             = 1'b0;
        s_valid           = 1'b0;
        s_kind            = spq_pkg::KIND_NOP;
        s_word            = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Dequeue and clear on an empty queue, an unused kind
        // with nonzero fields, then a fill to capacity whose levels run over
        // all eight codes so the saturated ones tie with the top level and
        // the order within a level is visible, one refused enqueue, a few
        // dequeues and a clear of a nonempty queue.
        send_op(spq_pkg::KIND_DEQ, 3'd7, 16'hFFFF);
        send_op(spq_pkg::KIND_NOP, 3'd5, 16'h1234);
        send_op(spq_pkg::KIND_CLR, 3'd0, 16'h0000);
        for (int i = 0; i < spq_pkg::DEPTH; i++)
            send_op(spq_pkg::KIND_ENQ, spq_pkg::LVL_W'(i % 8),
                    spq_pkg::TAG_BITS'(16'h1111 * i));
        send_op(spq_pkg::KIND_ENQ, 3'd7, 16'hFFFF);
        send_op(spq_pkg::KIND_NOP, 3'd7, 16'hFFFF);
        repeat (3) send_op(spq_pkg::KIND_DEQ, 3'd0, 16'h0000);
        send_op(spq_pkg::KIND_CLR, 3'd5, 16'hA5A5);
        send_op(spq_pkg::KIND_DEQ, 3'd2, 16'h5A5A);
        wait_for_results();

        run_random_traffic(1524);

        // Drain, then keep watching for stray words before the final count.
        idle_cycles(1);
        guard = 0;
        while (sb.expected_words.size() != 0 && guard < 5000) begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        leftover = sb.expected_words.size();
        if (leftover != 0)
            $display("%0d result words never arrived", leftover);

        $display("ran %0d operations: %0d stored, %0d served, %0d refused on a full queue",
                 sb.n_checked + leftover, sb.n_stored, sb.n_served, sb.n_refused);
        $display("%0d dequeues on empty, %0d clears, %0d ignored kinds, peak depth %0d",
                 sb.n_empty_deq, sb.n_cleared, sb.n_ignored, sb.peak_depth);
        if (sb.failures == 0 && leftover == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
